// ----- rtl/ili_pkg.sv -----
package ili_pkg;

  localparam int CAPACITY = 16;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 8;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = POS_W + 1;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_READ   = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_NONE   = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_CAP  = 2'd2,
    STAT_LEN  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FETCH,
    ST_GRAB,
    ST_STEP,
    ST_MOVE,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
  } mem_ctl_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_out;
    status_t           status;
    logic [CNT_W-1:0]  count_now;
  } result_t;

endpackage

// ----- rtl/ili_if.sv -----
interface ili_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      req_type;
  logic [ili_pkg::POS_W-1:0]       position;
  logic [ili_pkg::WORD_W-1:0]      word_in;

  modport source (output valid, req_type, position, word_in, input ready);
  modport sink (input valid, req_type, position, word_in, output ready);
endinterface

interface ili_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [ili_pkg::WORD_W-1:0]      word_out;
  logic [1:0]                      status;
  logic [ili_pkg::CNT_W-1:0]       count_now;

  modport source (output valid, word_out, status, count_now, input ready);
  modport sink (input valid, word_out, status, count_now, output ready);
endinterface

// ----- rtl/ili_store.sv -----
module ili_store (
  input  logic                        clk,
  input  logic                        rst,
  input  ili_pkg::mem_ctl_t           mem_ctl,
  output logic [ili_pkg::WORD_W-1:0]  rd_data
);
  import ili_pkg::*;

  logic [WORD_W-1:0]   mem [CAPACITY];
  logic [CAPACITY-1:0] filled;
  logic [WORD_W-1:0]   rd_word;
  logic                rd_filled;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[mem_ctl.wr_addr] <= mem_ctl.wr_data;
    end
    if (mem_ctl.rd_en) begin
      rd_word <= mem[mem_ctl.rd_addr];
    end
  end

  // a slot never written since reset reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      rd_filled <= 1'b0;
    end else begin
      if (mem_ctl.wr_en) begin
        filled[mem_ctl.wr_addr] <= 1'b1;
      end
      if (mem_ctl.rd_en) begin
        rd_filled <= filled[mem_ctl.rd_addr];
      end
    end
  end

  assign rd_data = rd_filled ? rd_word : '0;

endmodule

// ----- rtl/ili_ctrl.sv -----
module ili_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  ili_req_if.sink                     req,
  output ili_pkg::mem_ctl_t           mem_ctl,
  input  logic [ili_pkg::WORD_W-1:0]  rd_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output ili_pkg::result_t            res
);
  import ili_pkg::*;

  seq_state_t        state, state_next;
  req_kind_t         kind;
  logic [POS_W-1:0]  pos;
  logic [WORD_W-1:0] word;
  logic [IDX_W-1:0]  ptr, ptr_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [WORD_W-1:0] res_word, res_word_next;
  status_t           res_status, res_status_next;

  logic              pos_over;
  logic              pos_past_cnt;
  logic              pos_at_cnt;
  logic              list_full;
  logic [CNT_W-1:0]  nb;
  logic              at_target;
  logic              at_top;

  // shared pointer unit: neighbour slot and end tests
  assign pos_over     = {1'b0, pos} >= CMP_W'(CAPACITY);
  assign pos_past_cnt = {1'b0, pos} > CMP_W'(cnt);
  assign pos_at_cnt   = {1'b0, pos} == CMP_W'(cnt);
  assign list_full    = cnt == CNT_W'(CAPACITY);
  assign nb           = (kind == REQ_INSERT) ? CNT_W'(ptr) - CNT_W'(1)
                                             : CNT_W'(ptr) + CNT_W'(1);
  assign at_target    = ptr == pos[IDX_W-1:0];
  assign at_top       = nb == cnt;

  assign req.ready = state == ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      kind <= req_kind_t'(req.req_type);
      pos  <= req.position;
      word <= req.word_in;
    end
    ptr        <= ptr_next;
    res_word   <= res_word_next;
    res_status <= res_status_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        case (kind)
          REQ_INSERT: begin
            state_next = (list_full || pos_over || pos_past_cnt) ? ST_DONE : ST_STEP;
          end
          REQ_READ: begin
            state_next = pos_over ? ST_DONE : ST_FETCH;
          end
          REQ_DELETE: begin
            state_next = (pos_over || pos_past_cnt || pos_at_cnt) ? ST_DONE : ST_GRAB;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_FETCH: state_next = ST_DONE;
      ST_GRAB:  state_next = ST_STEP;
      ST_STEP: begin
        if (kind == REQ_INSERT) begin
          state_next = at_target ? ST_DONE : ST_MOVE;
        end else begin
          state_next = at_top ? ST_DONE : ST_MOVE;
        end
      end
      ST_MOVE: state_next = ST_STEP;
      ST_DONE: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl         = '0;
    ptr_next        = ptr;
    cnt_next        = cnt;
    res_word_next   = res_word;
    res_status_next = res_status;
    case (state)
      ST_DECODE: begin
        res_word_next   = '0;
        res_status_next = STAT_OK;
        case (kind)
          REQ_INSERT: begin
            if (list_full) begin
              res_status_next = STAT_FULL;
            end else if (pos_over) begin
              res_status_next = STAT_CAP;
            end else if (pos_past_cnt) begin
              res_status_next = STAT_LEN;
            end
            ptr_next = cnt[IDX_W-1:0];
          end
          REQ_READ: begin
            if (pos_over) begin
              res_status_next = STAT_CAP;
            end else begin
              mem_ctl.rd_en   = 1'b1;
              mem_ctl.rd_addr = pos[IDX_W-1:0];
            end
          end
          REQ_DELETE: begin
            if (pos_over) begin
              res_status_next = STAT_CAP;
            end else if (pos_past_cnt || pos_at_cnt) begin
              res_status_next = STAT_LEN;
            end else begin
              mem_ctl.rd_en   = 1'b1;
              mem_ctl.rd_addr = pos[IDX_W-1:0];
            end
          end
          default: ;
        endcase
      end
      ST_FETCH: begin
        res_word_next = rd_data;
      end
      ST_GRAB: begin
        res_word_next = rd_data;
        ptr_next      = pos[IDX_W-1:0];
      end
      ST_STEP: begin
        if (kind == REQ_INSERT) begin
          if (at_target) begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = ptr;
            mem_ctl.wr_data = word;
            cnt_next        = cnt + CNT_W'(1);
          end else begin
            mem_ctl.rd_en   = 1'b1;
            mem_ctl.rd_addr = nb[IDX_W-1:0];
          end
        end else begin
          if (at_top) begin
            cnt_next = cnt - CNT_W'(1);
          end else begin
            mem_ctl.rd_en   = 1'b1;
            mem_ctl.rd_addr = nb[IDX_W-1:0];
          end
        end
      end
      ST_MOVE: begin
        mem_ctl.wr_en   = 1'b1;
        mem_ctl.wr_addr = ptr;
        mem_ctl.wr_data = rd_data;
        ptr_next        = nb[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  assign res_valid     = state == ST_DONE;
  assign res.word_out  = res_word;
  assign res.status    = res_status;
  assign res.count_now = cnt;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("list count beyond capacity");

  a_port_single: assert property (@(posedge clk) disable iff (rst)
    !(mem_ctl.wr_en && mem_ctl.rd_en))
    else $error("store read and write in the same cycle");

  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    !$stable(cnt) |-> $past(state) == ST_STEP)
    else $error("count changed outside the final step");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result changed before hand-off");

endmodule

// ----- rtl/indexed_list_insert_delete_top.sv -----
// Ordered list of up to CAPACITY words held in a store used as a single port,
// with one request handled at a time. A small sequencer walks a shared pointer
// unit over the store, moving one entry at a time (read, then write one slot
// over), so the cost grows with the number of entries that must shift. An
// error or an unknown request goes straight to its response. Responses
// sit in an output register, so the next request is taken while the last
// response still waits. The store reads as zero after reset without any
// clearing pass; a slot freed by a delete keeps its old word.
module indexed_list_insert_delete_top (
  input  logic clk,
  input  logic rst,
  ili_req_if.sink   req,
  ili_rsp_if.source rsp
);
  import ili_pkg::*;

  mem_ctl_t          mem_ctl;
  logic [WORD_W-1:0] rd_data;
  logic              res_valid;
  logic              res_ready;
  result_t           res;

  logic              out_valid;
  result_t           out_word;

  ili_store u_store (
    .clk     (clk),
    .rst     (rst),
    .mem_ctl (mem_ctl),
    .rd_data (rd_data)
  );

  ili_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .mem_ctl   (mem_ctl),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output word register
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.word_out  = out_word.word_out;
  assign rsp.status    = out_word.status;
  assign rsp.count_now = out_word.count_now;

endmodule
